// ===== rtl/pwmc_pkg.sv =====
// Package: shared types and constants for pulse width and period capture.
package pwmc_pkg;

   localparam int DataWidth   = 32;
   localparam int OffsetWidth = 8;

   // Event kinds on the request channel
   typedef enum logic {
      CMD_OVERFLOW = 1'b0,
      CMD_CAPTURE  = 1'b1
   } cmd_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_OVERFLOW_SPAN  = 1'b0,
      CSR_CAPTURE_OFFSET = 1'b1
   } csr_index_type;

   localparam logic [DataWidth-1:0]   SpanReset   = 32'd65535;
   localparam logic [OffsetWidth-1:0] OffsetReset = 8'd3;
   localparam logic [DataWidth-1:0]   PeriodReset = 32'd20;

   // Edge tracking flags
   typedef struct packed {
      logic high_seen;
      logic falling_seen;
   } phase_type;

   // Per-item status bits
   typedef struct packed {
      logic width_updated;
      logic period_updated;
      logic timed_out;
      logic restart_counter;
   } status_type;

endpackage

// ===== rtl/pwmc_step.sv =====
// Next-state and result logic for one timer event.
module pwmc_step #(
   parameter int OVERFLOW_BITS = 6
) (
   input  pwmc_pkg::cmd_type                   cmd,
   input  logic [pwmc_pkg::DataWidth-1:0]      capture_count,
   input  logic [pwmc_pkg::DataWidth-1:0]      overflow_span,
   input  logic [pwmc_pkg::OffsetWidth-1:0]    capture_offset,
   input  logic [OVERFLOW_BITS-1:0]            ovf_cnt,
   input  pwmc_pkg::phase_type                 phase,
   input  logic [pwmc_pkg::DataWidth-1:0]      width_cur,
   input  logic [pwmc_pkg::DataWidth-1:0]      period_cur,
   output logic [OVERFLOW_BITS-1:0]            ovf_cnt_next,
   output pwmc_pkg::phase_type                 phase_next,
   output logic [pwmc_pkg::DataWidth-1:0]      width_next,
   output logic [pwmc_pkg::DataWidth-1:0]      period_next,
   output pwmc_pkg::status_type                status
);
   import pwmc_pkg::*;

   localparam int ProdWidth = OVERFLOW_BITS + DataWidth;

   logic [ProdWidth-1:0] product;
   logic [ProdWidth-1:0] span_shifted;
   logic [DataWidth-1:0] measured;
   logic [DataWidth-1:0] timeout_period;
   logic                 ovf_at_max;

   assign product = {{OVERFLOW_BITS{1'b0}}, overflow_span}
                  * {{DataWidth{1'b0}}, ovf_cnt};
   assign measured = product[DataWidth-1:0] + capture_count
                   + {{(DataWidth-OffsetWidth){1'b0}}, capture_offset};

   // max count times span = (span << bits) - span
   assign span_shifted   = {overflow_span, {OVERFLOW_BITS{1'b0}}};
   assign timeout_period = span_shifted[DataWidth-1:0] - overflow_span;
   assign ovf_at_max     = &ovf_cnt;

   always_comb begin
      ovf_cnt_next = ovf_cnt;
      phase_next   = phase;
      width_next   = width_cur;
      period_next  = period_cur;
      status       = '0;
      case (cmd)
         CMD_OVERFLOW: begin
            if (ovf_at_max) begin
               period_next           = timeout_period;
               ovf_cnt_next          = '0;
               phase_next            = '0;
               status.period_updated = 1'b1;
               status.timed_out      = 1'b1;
            end else begin
               ovf_cnt_next = ovf_cnt + 1'b1;
            end
         end
         CMD_CAPTURE: begin
            if (phase.high_seen) begin
               width_next              = measured;
               phase_next.high_seen    = 1'b0;
               phase_next.falling_seen = 1'b1;
               status.width_updated    = 1'b1;
            end else if (phase.falling_seen) begin
               period_next             = measured;
               ovf_cnt_next            = '0;
               phase_next.falling_seen = 1'b0;
               status.period_updated   = 1'b1;
            end else begin
               ovf_cnt_next           = '0;
               phase_next.high_seen   = 1'b1;
               status.restart_counter = 1'b1;
            end
         end
         default: begin
            ovf_cnt_next = ovf_cnt;
         end
      endcase
   end

endmodule

// ===== rtl/pwm_width_period_capture_top.sv =====
// Top level: pulse high width and period capture from timer events.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_cmd, req_capture_count
//   rsp     | out       | rsp_valid/rsp_ready   | width, period, status bits
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One item per cycle sustained while rsp is not stalled; an item passes the
// input register, then the multiply-add stage into the result register,
// which also updates the measurement state, and then shows on rsp.
// Synchronous active-high reset clears both valids, the overflow count, phase
// and width, and loads the reset span, offset and period. A stalled rsp holds
// its item; req stays ready while the input stage is empty or can move on.
module pwm_width_period_capture_top #(
   parameter int OVERFLOW_BITS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [pwmc_pkg::DataWidth-1:0]      req_capture_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pwmc_pkg::DataWidth-1:0]      rsp_pulse_width,
   output logic [pwmc_pkg::DataWidth-1:0]      rsp_pulse_period,
   output logic                                rsp_width_updated,
   output logic                                rsp_period_updated,
   output logic                                rsp_timed_out,
   output logic                                rsp_restart_counter,
   output logic                                rsp_watch_falling,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [pwmc_pkg::DataWidth-1:0]      csr_data
);
   import pwmc_pkg::*;

   // configuration
   logic [DataWidth-1:0]   span_ff;
   logic [OffsetWidth-1:0] offset_ff;

   // input stage
   logic                 in_valid_ff;
   cmd_type              in_cmd_ff;
   logic [DataWidth-1:0] in_count_ff;

   // measurement state
   logic [OVERFLOW_BITS-1:0] ovf_cnt_ff;
   phase_type                phase_ff;
   logic [DataWidth-1:0]     width_ff;
   logic [DataWidth-1:0]     period_ff;

   // result stage
   logic                 out_valid_ff;
   status_type           out_status_ff;
   logic                 out_watch_ff;

   logic [OVERFLOW_BITS-1:0] ovf_cnt_in;
   phase_type                phase_in;
   logic [DataWidth-1:0]     width_in;
   logic [DataWidth-1:0]     period_in;
   status_type               status_in;
   logic                     step_fire;
   logic                     req_fire;

   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   pwmc_step #(
      .OVERFLOW_BITS (OVERFLOW_BITS)
   ) u_step (
      .cmd            (in_cmd_ff),
      .capture_count  (in_count_ff),
      .overflow_span  (span_ff),
      .capture_offset (offset_ff),
      .ovf_cnt        (ovf_cnt_ff),
      .phase          (phase_ff),
      .width_cur      (width_ff),
      .period_cur     (period_ff),
      .ovf_cnt_next   (ovf_cnt_in),
      .phase_next     (phase_in),
      .width_next     (width_in),
      .period_next    (period_in),
      .status         (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff   <= SpanReset;
         offset_ff <= OffsetReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OVERFLOW_SPAN:  span_ff   <= csr_data;
            CSR_CAPTURE_OFFSET: offset_ff <= csr_data[OffsetWidth-1:0];
            default:            span_ff   <= span_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_fire) begin
         in_cmd_ff   <= cmd_type'(req_cmd);
         in_count_ff <= req_capture_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_cnt_ff <= '0;
         phase_ff   <= '0;
         width_ff   <= '0;
         period_ff  <= PeriodReset;
      end else if (step_fire) begin
         ovf_cnt_ff <= ovf_cnt_in;
         phase_ff   <= phase_in;
         width_ff   <= width_in;
         period_ff  <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (step_fire) begin
         out_status_ff <= status_in;
         out_watch_ff  <= phase_in.high_seen;
      end
   end

   // width/period registers double as the result payload
   assign rsp_valid           = out_valid_ff;
   assign rsp_pulse_width     = width_ff;
   assign rsp_pulse_period    = period_ff;
   assign rsp_width_updated   = out_status_ff.width_updated;
   assign rsp_period_updated  = out_status_ff.period_updated;
   assign rsp_timed_out       = out_status_ff.timed_out;
   assign rsp_restart_counter = out_status_ff.restart_counter;
   assign rsp_watch_falling   = out_watch_ff;

endmodule

// ===== rtl/pwmc_checker.sv =====
// Checker: port-level properties of the capture block, bound to the top level.
module pwmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pulse_width,
   input logic [31:0] rsp_pulse_period,
   input logic        rsp_width_updated,
   input logic        rsp_period_updated,
   input logic        rsp_timed_out,
   input logic        rsp_restart_counter,
   input logic        rsp_watch_falling
);

   // no result right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_width)
         && $stable(rsp_pulse_period) && $stable(rsp_width_updated)
         && $stable(rsp_watch_falling))
      else $error("rsp item changed while stalled");

   // timeout writes the period only and re-arms for a rising edge
   a_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_period_updated && !rsp_width_updated
         && !rsp_restart_counter && !rsp_watch_falling)
      else $error("timeout result inconsistent");

   // first rising edge arms falling capture and updates nothing
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restart_counter |-> rsp_watch_falling
         && !rsp_width_updated && !rsp_period_updated)
      else $error("restart result inconsistent");

   // falling edge disarms falling capture
   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_width_updated |-> !rsp_watch_falling
         && !rsp_period_updated && !rsp_timed_out)
      else $error("width result inconsistent");

endmodule

bind pwm_width_period_capture_top pwmc_checker u_pwmc_checker (.*);
